// ===== design/sbsw_pkg.sv =====
// Shared types, constants and the acos table builder of the slope band splat block.
package sbsw_pkg;

   localparam int unsigned NORMAL_W    = 16;
   localparam int unsigned RGB_W       = 24;
   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned COVER_W     = 7;
   localparam int unsigned HEIGHT_W    = 16;
   localparam int unsigned SLOPE_W     = 17;
   localparam int unsigned SCALE_W     = SLOPE_W + HEIGHT_W;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam int unsigned REQ_DATA_W  = NORMAL_W + 3 * RGB_W;
   localparam int unsigned RSP_DATA_W  = 72;
   localparam int unsigned RSP_USED_W  = 2 * RGB_W + 3 * COVER_W;

   // Quotient bits resolved per divider stage.
   localparam int unsigned DIV_STEPS = 4;

   localparam logic [HEIGHT_W-1:0] BAND_HEIGHT_RESET = 16'd128;
   localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_RESET  = 16'd256;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BAND_HEIGHT  = 3'd0,
      CSR_MAX_HEIGHT   = 3'd1,
      CSR_COLOUR_FLAT  = 3'd2,
      CSR_COLOUR_MID   = 3'd3,
      CSR_COLOUR_STEEP = 3'd4
   } csr_index_type;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] HORNER_DIV [6] = '{64'd182, 64'd132, 64'd90, 64'd56, 64'd30, 64'd12};
   localparam logic [63:0] SLOPE_FULL  = 64'd65536;

   // Cosine of a quarter turn scaled by s (Q0.16), as a Q2.30 Horner series clamped at zero.
   function automatic logic [63:0] cos_q30(input logic [63:0] s);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] r;
      logic [63:0] t;
      x  = (s * HALF_PI_Q30) >> 16;
      x2 = (x * x) >> 30;
      r  = Q30_ONE;
      for (int i = 0; i < 6; i++) begin
         r = Q30_ONE - ((x2 * r) >> 30) / HORNER_DIV[i];
      end
      t = (x2 * r) >> 31;
      return (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
   endfunction

   // Largest s whose cosine is still at or above k / 2^table_bits.
   function automatic logic [SLOPE_W-1:0] acos_entry(input int unsigned k,
                                                     input int unsigned table_bits);
      logic [63:0] y;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      y  = 64'(k) << (30 - table_bits);
      lo = 64'd0;
      hi = SLOPE_FULL;
      while (lo < hi) begin
         mid = (lo + hi + 64'd1) >> 1;
         if (cos_q30(mid) >= y) begin
            lo = mid;
         end else begin
            hi = mid - 64'd1;
         end
      end
      return lo[SLOPE_W-1:0];
   endfunction

endpackage

// ===== design/slope_band_splat_weights_top.sv =====
// Slope band splat weights: pipelined slope, band fraction, base colour and texel blend.
//
//   Channel  Direction  Word contents (lowest bits first)
//   req      in         normal_up[15:0], texel_a, texel_b, texel_c
//   rsp      out        base_colour, blend_colour, cover_a, cover_b, cover_c, zero pad
//   csr      in         csr_index selects the register, csr_data holds its value
//
// One word enters per cycle while rsp is not stalled. The band fraction divider
// resolves four quotient bits per stage and sets the depth.
// Reset clears all stage valid bits and loads the register defaults.
// A stall at rsp holds the last stage; earlier stages keep filling bubbles, so words are
// taken on req while a finished result waits, until no bubble remains.
module slope_band_splat_weights_top #(
   parameter int unsigned ACOS_TABLE_BITS = 10,
   parameter int unsigned FRACTION_BITS   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // normal_up[15:0], texel_a[39:16], texel_b[63:40], texel_c[87:64]
   input  logic [sbsw_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // base_colour[23:0], blend_colour[47:24], cover_a[54:48], cover_b[61:55],
   // cover_c[68:62], zeros[71:69]
   output logic [sbsw_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sbsw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sbsw_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sbsw_pkg::*;

   localparam int unsigned SHIFT_W     = 15 - ACOS_TABLE_BITS;
   localparam int unsigned ROM_ENTRIES = (1 << ACOS_TABLE_BITS) + 1;
   localparam int unsigned ROM_IDX_W   = ACOS_TABLE_BITS + 1;
   localparam int unsigned DFRAC_W     = SLOPE_W + SHIFT_W;
   localparam int unsigned T_W         = FRACTION_BITS + 1;
   localparam int unsigned PROD_W      = FRACTION_BITS + CHAN_W + 1;
   localparam int unsigned DIV_TOTAL   = FRACTION_BITS + 1;
   localparam int unsigned DIV_STAGES  = (DIV_TOTAL + DIV_STEPS - 1) / DIV_STEPS;
   localparam int unsigned ST_ROM      = 1;
   localparam int unsigned ST_INTERP   = 2;
   localparam int unsigned ST_SCALE    = 3;
   localparam int unsigned ST_BAND     = 4;
   localparam int unsigned ST_DIV0     = 5;
   localparam int unsigned ST_MUL      = ST_DIV0 + DIV_STAGES;
   localparam int unsigned ST_OUT      = ST_MUL + 1;
   localparam int unsigned NUM_STAGES  = ST_OUT + 1;
   localparam logic [T_W-1:0] T_ONE    = {1'b1, {FRACTION_BITS{1'b0}}};

   // Configuration registers.
   logic [HEIGHT_W-1:0] band_height_ff;
   logic [HEIGHT_W-1:0] max_height_ff;
   logic [RGB_W-1:0]    colour_flat_ff;
   logic [RGB_W-1:0]    colour_mid_ff;
   logic [RGB_W-1:0]    colour_steep_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_height_ff  <= BAND_HEIGHT_RESET;
         max_height_ff   <= MAX_HEIGHT_RESET;
         colour_flat_ff  <= '0;
         colour_mid_ff   <= '0;
         colour_steep_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BAND_HEIGHT:  band_height_ff  <= csr_data[HEIGHT_W-1:0];
            CSR_MAX_HEIGHT:   max_height_ff   <= csr_data[HEIGHT_W-1:0];
            CSR_COLOUR_FLAT:  colour_flat_ff  <= csr_data[RGB_W-1:0];
            CSR_COLOUR_MID:   colour_mid_ff   <= csr_data[RGB_W-1:0];
            CSR_COLOUR_STEEP: colour_steep_ff <= csr_data[RGB_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage flow control: a stage loads when it is empty or the one after it moves on.
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES:0]   ready;

   assign ready[NUM_STAGES] = rsp_tready;
   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_ready
      assign ready[k] = !valid_ff[k] || ready[k+1];
   end

   always_comb begin
      valid_in = valid_ff;
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (ready[k]) begin
            valid_in[k] = (k == 0) ? req_tvalid : valid_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = ready[0];

   // Texels ride along until the multiply stage picks the two that matter.
   logic [3*RGB_W-1:0] texel_ff [ST_MUL];

   for (genvar k = 0; k < ST_MUL; k++) begin : g_texel
      always_ff @(posedge clock) begin
         if (ready[k]) begin
            texel_ff[k] <= (k == 0) ? req_tdata[NORMAL_W +: 3*RGB_W]
                                    : texel_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   // Input stage.
   logic [NORMAL_W-1:0] normal_ff;

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         normal_ff <= req_tdata[NORMAL_W-1:0];
      end
   end

   // Arc cosine table, built at elaboration.
   logic [SLOPE_W-1:0] acos_rom [ROM_ENTRIES];

   for (genvar k = 0; k < ROM_ENTRIES; k++) begin : g_rom
      localparam logic [SLOPE_W-1:0] ENTRY = acos_entry(k, ACOS_TABLE_BITS);
      assign acos_rom[k] = ENTRY;
   end

   // Table stage: a negative normal counts as zero, which reads the vertical end.
   logic [14:0]          normal_pos;
   logic [ROM_IDX_W-1:0] rom_idx;
   logic [SLOPE_W-1:0]   rom_a_ff;
   logic [SLOPE_W-1:0]   rom_b_ff;
   logic [SHIFT_W-1:0]   frac_ff;

   assign normal_pos = normal_ff[NORMAL_W-1] ? 15'd0 : normal_ff[14:0];
   assign rom_idx    = {1'b0, normal_pos[14:SHIFT_W]};

   always_ff @(posedge clock) begin
      if (ready[ST_ROM]) begin
         rom_a_ff <= acos_rom[rom_idx];
         rom_b_ff <= acos_rom[rom_idx + ROM_IDX_W'(1)];
         frac_ff  <= normal_pos[SHIFT_W-1:0];
      end
   end

   // Interpolation stage.
   logic [SLOPE_W-1:0] rom_d;
   logic [DFRAC_W-1:0] dfrac;
   logic [SLOPE_W-1:0] slope_ff;

   assign rom_d = (rom_a_ff >= rom_b_ff) ? rom_a_ff - rom_b_ff : '0;
   assign dfrac = DFRAC_W'(rom_d) * DFRAC_W'(frac_ff);

   always_ff @(posedge clock) begin
      if (ready[ST_INTERP]) begin
         slope_ff <= rom_a_ff - dfrac[SHIFT_W +: SLOPE_W];
      end
   end

   // Scale stage: slope height in Q8.8.
   logic [SCALE_W-1:0]  scaled;
   logic [HEIGHT_W-1:0] height_ff;

   assign scaled = SCALE_W'(slope_ff) * SCALE_W'(max_height_ff);

   always_ff @(posedge clock) begin
      if (ready[ST_SCALE]) begin
         height_ff <= scaled[HEIGHT_W +: HEIGHT_W];
      end
   end

   // Band stage and divider pipeline. Index s of the divider arrays feeds divider stage s.
   logic [HEIGHT_W-1:0] rem_ff    [DIV_STAGES];
   logic [HEIGHT_W-1:0] span_ff   [DIV_STAGES];
   logic [T_W-1:0]      quo_ff    [DIV_STAGES+1];
   logic                second_ff [DIV_STAGES+1];
   logic                zero_ff   [DIV_STAGES+1];
   logic                band_second;
   logic [HEIGHT_W-1:0] band_span;

   assign band_second = height_ff > band_height_ff;
   assign band_span   = band_second ? max_height_ff - band_height_ff : band_height_ff;

   always_ff @(posedge clock) begin
      if (ready[ST_BAND]) begin
         rem_ff[0]    <= band_second ? height_ff - band_height_ff : height_ff;
         span_ff[0]   <= band_span;
         quo_ff[0]    <= '0;
         second_ff[0] <= band_second;
         zero_ff[0]   <= (band_span == '0);
      end
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      logic [HEIGHT_W-1:0] rem_next;
      logic [T_W-1:0]      quo_next;

      // The numerator never exceeds the span, so the first step compares without doubling.
      always_comb begin
         logic [HEIGHT_W:0] trial;
         rem_next = rem_ff[s];
         quo_next = quo_ff[s];
         trial    = '0;
         for (int j = 0; j < DIV_STEPS; j++) begin
            if (s * DIV_STEPS + j < DIV_TOTAL) begin
               trial = (s * DIV_STEPS + j == 0) ? {1'b0, rem_next} : {rem_next, 1'b0};
               if (trial >= {1'b0, span_ff[s]}) begin
                  trial    = trial - {1'b0, span_ff[s]};
                  quo_next = {quo_next[T_W-2:0], 1'b1};
               end else begin
                  quo_next = {quo_next[T_W-2:0], 1'b0};
               end
               rem_next = trial[HEIGHT_W-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (ready[ST_DIV0 + s]) begin
            quo_ff[s+1]    <= quo_next;
            second_ff[s+1] <= second_ff[s];
            zero_ff[s+1]   <= zero_ff[s];
         end
      end

      if (s + 1 < DIV_STAGES) begin : g_carry
         always_ff @(posedge clock) begin
            if (ready[ST_DIV0 + s]) begin
               rem_ff[s+1]  <= rem_next;
               span_ff[s+1] <= span_ff[s];
            end
         end
      end
   end

   // Multiply stage: weights, end colours and the two texels of the active band.
   logic [T_W-1:0]       frac_t;
   logic [T_W-1:0]       frac_omt;
   logic                 mul_second;
   logic [RGB_W-1:0]     colour_lo;
   logic [RGB_W-1:0]     colour_hi;
   logic [RGB_W-1:0]     texel_lo;
   logic [RGB_W-1:0]     texel_hi;
   logic [T_W-1:0]       weight [3];
   logic [PROD_W-1:0]    weight255 [3];
   logic [PROD_W-1:0]    base_lo_ff  [3];
   logic [PROD_W-1:0]    base_hi_ff  [3];
   logic [PROD_W-1:0]    blend_lo_ff [3];
   logic [PROD_W-1:0]    blend_hi_ff [3];
   logic [COVER_W-1:0]   cover_ff [3];

   assign mul_second = second_ff[DIV_STAGES];
   assign frac_t     = zero_ff[DIV_STAGES] ? '0 : quo_ff[DIV_STAGES];
   assign frac_omt   = T_ONE - frac_t;
   assign colour_lo  = mul_second ? colour_mid_ff : colour_flat_ff;
   assign colour_hi  = mul_second ? colour_steep_ff : colour_mid_ff;
   assign texel_lo   = mul_second ? texel_ff[ST_MUL-1][RGB_W +: RGB_W]
                                  : texel_ff[ST_MUL-1][0 +: RGB_W];
   assign texel_hi   = mul_second ? texel_ff[ST_MUL-1][2*RGB_W +: RGB_W]
                                  : texel_ff[ST_MUL-1][RGB_W +: RGB_W];
   assign weight[0]  = mul_second ? '0 : frac_omt;
   assign weight[1]  = mul_second ? frac_omt : frac_t;
   assign weight[2]  = mul_second ? frac_t : '0;

   for (genvar c = 0; c < 3; c++) begin : g_mul
      assign weight255[c] = {weight[c], {CHAN_W{1'b0}}} - PROD_W'(weight[c]);

      always_ff @(posedge clock) begin
         if (ready[ST_MUL]) begin
            base_lo_ff[c]  <= PROD_W'(colour_lo[c*CHAN_W +: CHAN_W]) * PROD_W'(frac_omt);
            base_hi_ff[c]  <= PROD_W'(colour_hi[c*CHAN_W +: CHAN_W]) * PROD_W'(frac_t);
            blend_lo_ff[c] <= PROD_W'(texel_lo[c*CHAN_W +: CHAN_W]) * PROD_W'(frac_omt);
            blend_hi_ff[c] <= PROD_W'(texel_hi[c*CHAN_W +: CHAN_W]) * PROD_W'(frac_t);
            cover_ff[c]    <= weight255[c][FRACTION_BITS+1 +: COVER_W];
         end
      end
   end

   // Output stage: sums, scaling and packing into the result register.
   logic [RGB_W-1:0]      base_colour;
   logic [RGB_W-1:0]      blend_colour;
   logic [PROD_W-1:0]     base_sum  [3];
   logic [PROD_W-1:0]     blend_sum [3];
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   for (genvar c = 0; c < 3; c++) begin : g_sum
      assign base_sum[c]  = base_lo_ff[c] + base_hi_ff[c];
      assign blend_sum[c] = blend_lo_ff[c] + blend_hi_ff[c];
      assign base_colour[c*CHAN_W +: CHAN_W]  = base_sum[c][FRACTION_BITS +: CHAN_W];
      assign blend_colour[c*CHAN_W +: CHAN_W] = blend_sum[c][FRACTION_BITS+1 +: CHAN_W];
   end

   always_ff @(posedge clock) begin
      if (ready[ST_OUT]) begin
         rsp_data_ff <= {{(RSP_DATA_W-RSP_USED_W){1'b0}}, cover_ff[2], cover_ff[1],
                         cover_ff[0], blend_colour, base_colour};
      end
   end

   assign rsp_tvalid = valid_ff[ST_OUT];
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/sbsw_checker.sv =====
// Port-level checks on the result channel of the slope band splat block, with its bind.
module sbsw_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sbsw_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sbsw_pkg::*;

   logic [COVER_W-1:0] cover_a;
   logic [COVER_W-1:0] cover_b;
   logic [COVER_W-1:0] cover_c;
   logic [COVER_W+1:0] cover_sum;

   assign cover_a   = rsp_tdata[2*RGB_W +: COVER_W];
   assign cover_b   = rsp_tdata[2*RGB_W+COVER_W +: COVER_W];
   assign cover_c   = rsp_tdata[2*RGB_W+2*COVER_W +: COVER_W];
   assign cover_sum = (COVER_W+2)'(cover_a) + (COVER_W+2)'(cover_b) + (COVER_W+2)'(cover_c);

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed or dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Only one band is active, so the first or the third texture has no coverage.
   a_one_band: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (cover_a == '0 || cover_c == '0))
      else $error("first and third coverage both nonzero");

   // The weights sum to one, so the floored coverages cannot sum above full scale.
   a_cover_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cover_sum <= (COVER_W+2)'(127))
      else $error("coverage sum above full scale");

endmodule

bind slope_band_splat_weights_top sbsw_checker u_sbsw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
